[sv/bst_pkg.sv]
package bst_pkg;

  localparam int MAX_WORD = 32;
  localparam int IDX_W    = $clog2(MAX_WORD);
  localparam int LEN_W    = $clog2(MAX_WORD + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_PUNCT   = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_EOI_STR  = 3'd2;
  localparam logic [2:0] ERR_NEWLINE  = 3'd3;
  localparam logic [2:0] ERR_RETURN   = 3'd4;
  localparam logic [2:0] ERR_TAB      = 3'd5;
  localparam logic [2:0] ERR_OTHER    = 3'd6;

  localparam logic [1:0] KW_DEFUNC = 2'd0;
  localparam logic [1:0] KW_VAR    = 2'd1;
  localparam logic [1:0] KW_IF     = 2'd2;
  localparam int         NUM_KW    = 3;

  localparam logic PUNCT_OPEN  = 1'b0;
  localparam logic PUNCT_CLOSE = 1'b1;

  // what the back end does before the main action of a queue entry
  localparam logic [1:0] PRE_NONE  = 2'd0;
  localparam logic [1:0] PRE_INT   = 2'd1;
  localparam logic [1:0] PRE_FLUSH = 2'd2;

  localparam logic [1:0] MAIN_NONE   = 2'd0;
  localparam logic [1:0] MAIN_WBYTE  = 2'd1;
  localparam logic [1:0] MAIN_RESULT = 2'd2;

  localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  kw;
    logic        punct;
    logic [30:0] ival;
    logic        sat;
    logic [7:0]  text;
    logic        has;
    logic        last;
    logic [2:0]  err;
  } bst_result_t;

  typedef struct packed {
    logic [1:0]       pre;
    logic             kw_hit;
    logic [1:0]       kw;
    logic [LEN_W-1:0] flen;
    logic [30:0]      ival;
    logic             sat;
    logic [1:0]       main;
    logic [IDX_W-1:0] widx;
    bst_result_t      res;
  } bst_entry_t;

  function automatic logic [LEN_W-1:0] kw_len(input logic [1:0] k);
    logic [LEN_W-1:0] r;
    case (k)
      KW_DEFUNC: r = LEN_W'(6);
      KW_VAR:    r = LEN_W'(3);
      KW_IF:     r = LEN_W'(2);
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      KW_DEFUNC: begin
        case (p)
          3'd0:    r = "d";
          3'd1:    r = "e";
          3'd2:    r = "f";
          3'd3:    r = "u";
          3'd4:    r = "n";
          3'd5:    r = "c";
          default: r = 8'h00;
        endcase
      end
      KW_VAR: begin
        case (p)
          3'd0:    r = "v";
          3'd1:    r = "a";
          3'd2:    r = "r";
          default: r = 8'h00;
        endcase
      end
      KW_IF: begin
        case (p)
          3'd0:    r = "i";
          3'd1:    r = "f";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic bst_result_t single_res(input logic [2:0] kind);
    bst_result_t r;
    r      = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic bst_result_t err_res(input logic [2:0] code);
    bst_result_t r;
    r      = single_res(KIND_ERROR);
    r.err  = code;
    return r;
  endfunction

endpackage

[sv/bst_front.sv]
module bst_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  input  logic               in_end_of_input,
  input  logic               q_full,
  output logic               q_push,
  output bst_pkg::bst_entry_t q_entry,
  output logic               halted
);
  import bst_pkg::*;

  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_HALT   = 3'd4;

  logic [2:0]        mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [NUM_KW-1:0] kw_ok_r, kw_ok_nxt;
  logic [30:0]       acc_r, acc_nxt;
  logic              sat_r, sat_nxt;

  logic [7:0]  c;
  logic        eoi;
  logic        is_alpha, is_digit, is_word, is_ws;
  logic [3:0]  dval;
  logic [34:0] acc_sum;
  logic        do_start;
  logic        accept;
  bst_entry_t  ent;

  assign c        = in_char_in;
  assign eoi      = in_end_of_input;
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_word  = is_alpha || is_digit || (c == "_");
  assign is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  assign dval     = c[3:0];

  // acc * 10 + digit
  assign acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'b0, dval};

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign halted   = (mode_r == MODE_HALT);

  always_comb begin
    ent       = '0;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    kw_ok_nxt = kw_ok_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    do_start  = 1'b0;

    case (mode_r)
      MODE_IDENT: begin
        if (!eoi && is_word) begin
          if (len_r >= LEN_W'(MAX_WORD)) begin
            ent.main = MAIN_RESULT;
            ent.res  = err_res(ERR_OTHER);
            mode_nxt = MODE_HALT;
          end else begin
            ent.main     = MAIN_WBYTE;
            ent.widx     = len_r[IDX_W-1:0];
            ent.res.text = c;
            len_nxt      = len_r + LEN_W'(1);
            for (int k = 0; k < NUM_KW; k++) begin
              kw_ok_nxt[k] = kw_ok_r[k] && (len_r < kw_len(2'(k))) &&
                             (c == kw_char(2'(k), len_r[2:0]));
            end
          end
        end else begin
          ent.pre  = PRE_FLUSH;
          ent.flen = len_r;
          for (int k = 0; k < NUM_KW; k++) begin
            if (kw_ok_r[k] && (len_r == kw_len(2'(k)))) begin
              ent.kw_hit = 1'b1;
              ent.kw     = 2'(k);
            end
          end
          len_nxt  = '0;
          do_start = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!eoi && is_digit) begin
          if (acc_sum[34:31] != 4'd0) begin
            acc_nxt = INT_MAX;
            sat_nxt = 1'b1;
          end else begin
            acc_nxt = acc_sum[30:0];
          end
        end else begin
          ent.pre  = PRE_INT;
          ent.ival = acc_r;
          ent.sat  = sat_r;
          acc_nxt  = '0;
          sat_nxt  = 1'b0;
          do_start = 1'b1;
        end
      end
      MODE_STRING: begin
        ent.main = MAIN_RESULT;
        if (eoi) begin
          ent.res  = err_res(ERR_EOI_STR);
          mode_nxt = MODE_HALT;
        end else if (c == 8'h22) begin
          ent.res  = single_res(KIND_STRING);
          mode_nxt = MODE_START;
        end else if (c < 8'd33 || c > 8'd126) begin
          mode_nxt = MODE_HALT;
          if (c == 8'h0a) begin
            ent.res = err_res(ERR_NEWLINE);
          end else if (c == 8'h0d) begin
            ent.res = err_res(ERR_RETURN);
          end else if (c == 8'h09) begin
            ent.res = err_res(ERR_TAB);
          end else begin
            ent.res = err_res(ERR_OTHER);
          end
        end else begin
          ent.res.kind = KIND_STRING;
          ent.res.text = c;
          ent.res.has  = 1'b1;
        end
      end
      MODE_START: begin
        do_start = 1'b1;
      end
      default: ;
    endcase

    // a byte that ends an identifier or number is handled as a fresh byte
    if (do_start) begin
      mode_nxt = MODE_START;
      if (eoi) begin
        ent.main = MAIN_RESULT;
        ent.res  = single_res(KIND_END);
      end else if (is_ws) begin
        ent.main = MAIN_NONE;
      end else if (is_alpha || c == "_") begin
        ent.main     = MAIN_WBYTE;
        ent.widx     = '0;
        ent.res.text = c;
        len_nxt      = LEN_W'(1);
        for (int k = 0; k < NUM_KW; k++) begin
          kw_ok_nxt[k] = (c == kw_char(2'(k), 3'd0));
        end
        mode_nxt = MODE_IDENT;
      end else if (is_digit) begin
        acc_nxt  = {27'b0, dval};
        sat_nxt  = 1'b0;
        mode_nxt = MODE_NUMBER;
      end else if (c == 8'h28) begin
        ent.main      = MAIN_RESULT;
        ent.res       = single_res(KIND_PUNCT);
        ent.res.punct = PUNCT_OPEN;
      end else if (c == 8'h29) begin
        ent.main      = MAIN_RESULT;
        ent.res       = single_res(KIND_PUNCT);
        ent.res.punct = PUNCT_CLOSE;
      end else if (c == 8'h22) begin
        mode_nxt = MODE_STRING;
      end else begin
        ent.main = MAIN_RESULT;
        ent.res  = err_res(ERR_BAD_CHAR);
        mode_nxt = MODE_HALT;
      end
    end
  end

  assign q_entry = ent;
  assign q_push  = accept && ((ent.pre != PRE_NONE) || (ent.main != MAIN_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      len_r   <= '0;
      kw_ok_r <= '0;
      acc_r   <= '0;
      sat_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      kw_ok_r <= kw_ok_nxt;
      acc_r   <= acc_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

[sv/bst_queue.sv]
module bst_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bst_pkg::bst_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output bst_pkg::bst_entry_t head
);
  import bst_pkg::*;

  bst_entry_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

[sv/bst_back.sv]
module bst_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  bst_pkg::bst_entry_t  q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bst_pkg::bst_result_t out_res
);
  import bst_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_FLUSH = 2'd1;
  localparam logic [1:0] B_MAIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  bst_entry_t       cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  bst_result_t      out_res_r, res_nxt;
  logic             load;
  logic             out_free;
  logic             pre_out;

  logic [7:0]       word_mem [MAX_WORD];
  logic [7:0]       rd_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    res_nxt   = out_res_r;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    we        = 1'b0;
    waddr     = q_head.widx;
    wdata     = q_head.res.text;
    pre_out   = 1'b0;

    case (state_r)
      B_IDLE: begin
        idx_nxt = '0;
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          case (q_head.pre)
            PRE_INT: begin
              load         = 1'b1;
              pre_out      = 1'b1;
              res_nxt      = single_res(KIND_INT);
              res_nxt.ival = q_head.ival;
              res_nxt.sat  = q_head.sat;
            end
            PRE_FLUSH: begin
              if (q_head.kw_hit) begin
                load       = 1'b1;
                pre_out    = 1'b1;
                res_nxt    = single_res(KIND_KEYWORD);
                res_nxt.kw = q_head.kw;
              end else begin
                state_nxt = B_FLUSH;
              end
            end
            default: ;
          endcase
          // main action, unless an identifier run comes first; a result behind a pre result waits in B_MAIN
          if (state_nxt == B_IDLE) begin
            if (q_head.main == MAIN_RESULT) begin
              if (pre_out) begin
                state_nxt = B_MAIN;
              end else begin
                load    = 1'b1;
                res_nxt = q_head.res;
              end
            end else if (q_head.main == MAIN_WBYTE) begin
              we = 1'b1;
            end
          end
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          load         = 1'b1;
          res_nxt      = '0;
          res_nxt.kind = KIND_IDENT;
          res_nxt.text = rd_q;
          res_nxt.has  = 1'b1;
          res_nxt.last = ((LEN_W'(idx_r) + LEN_W'(1)) == cur_r.flen);
          if (res_nxt.last) begin
            idx_nxt   = '0;
            state_nxt = (cur_r.main != MAIN_NONE) ? B_MAIN : B_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      B_MAIN: begin
        idx_nxt = '0;
        waddr   = cur_r.widx;
        wdata   = cur_r.res.text;
        if (cur_r.main == MAIN_RESULT) begin
          if (out_free) begin
            load      = 1'b1;
            res_nxt   = cur_r.res;
            state_nxt = B_IDLE;
          end
        end else begin
          we        = (cur_r.main == MAIN_WBYTE);
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  // read address follows the next run index so rd_q holds the current byte
  always_ff @(posedge clk) begin
    if (we) begin
      word_mem[waddr] <= wdata;
    end
    rd_q <= word_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[sv/byte_stream_tokenizer.sv]
// throughput: one byte per cycle while the command queue is not full;
// one result per cycle at the output register while out_stall is low
// an identifier run drains from the word buffer one character per cycle while out_stall
// is low, so a long run fills the four-entry command queue and stalls the input meanwhile
// reset: synchronous active-low rst_n clears lexer mode, counters, queue and output valid;
// the word buffer is not cleared
module byte_stream_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [1:0]  out_keyword_code,
  output logic        out_punct_code,
  output logic [30:0] out_int_value,
  output logic        out_int_saturated,
  output logic [7:0]  out_text_byte,
  output logic        out_has_byte,
  output logic        out_last_of_run,
  output logic [2:0]  out_error_code
);
  import bst_pkg::*;

  logic        q_push, q_full, q_pop, q_valid;
  bst_entry_t  q_entry, q_head;
  bst_result_t res;
  logic        front_halted;

  bst_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry),
    .halted          (front_halted)
  );

  bst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_token_kind    = res.kind;
  assign out_keyword_code  = res.kw;
  assign out_punct_code    = res.punct;
  assign out_int_value     = res.ival;
  assign out_int_saturated = res.sat;
  assign out_text_byte     = res.text;
  assign out_has_byte      = res.has;
  assign out_last_of_run   = res.last;
  assign out_error_code    = res.err;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue pushed while full");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == KIND_ERROR) |-> front_halted)
    else $error("error result while front end still running");

  a_run_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |->
      (out_token_kind == KIND_IDENT || out_token_kind == KIND_STRING))
    else $error("open run on a single-result token");

endmodule
